// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rsd_pkg.sv
package rsd_pkg;

	// field and register widths
	localparam int SAMPLE_W    = 16;
	localparam int CFG_W       = 15;
	localparam int LANES       = 2;
	// sum of squares, radius and its remainder
	localparam int SQ_W        = 2 * SAMPLE_W;
	localparam int ROOT_W      = 24;
	localparam int RAD_W       = 2 * ROOT_W;
	localparam int REM_W       = ROOT_W + 2;
	// radius carries 8 fraction bits
	localparam int RADIX_SHIFT = 8;
	localparam int EXC_W       = CFG_W + RADIX_SHIFT;
	localparam int PROD_W      = SAMPLE_W + EXC_W;
	// Q1.15 scale of the result
	localparam int FRAC_SHIFT  = 15;
	localparam int NUM_W       = PROD_W + FRAC_SHIFT + 1;
	localparam int DEN_W       = 2 * CFG_W;
	localparam int Q_W         = 16;

	localparam logic [CFG_W-1:0] FULL_SCALE_RST  = 15'd32767;
	localparam logic [CFG_W-1:0] DEAD_RADIUS_RST = 15'd7849;

	localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] OUT_MIN = 16'sh8000;

	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FULL_SCALE  = 1'b0,
		CFG_DEAD_RADIUS = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x_raw;
		logic signed [SAMPLE_W-1:0] y_raw;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x_scaled;
		logic signed [SAMPLE_W-1:0] y_scaled;
		logic                       in_dead_zone;
	} out_item_t;

	// travels alongside the square root
	typedef struct packed {
		logic [LANES-1:0][SAMPLE_W-1:0] mag;
		logic [LANES-1:0]               neg;
		logic                           dead;
		logic                           kill;
		logic                           clamp;
	} sq_side_t;

	// travels alongside the divider
	typedef struct packed {
		logic [LANES-1:0] neg;
		logic             dead;
		logic             kill;
	} dv_side_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_acc_t;

	// one digit of the bitwise integer square root
	function automatic sqrt_acc_t sqrt_step(input logic [REM_W-1:0] rem,
		input logic [ROOT_W-1:0] root, input logic [1:0] pair);
		sqrt_acc_t        res;
		logic [REM_W-1:0] acc;
		logic [REM_W-1:0] trial;
		acc   = {rem[REM_W-3:0], pair};
		trial = {root, 2'b01};
		if (acc >= trial) begin
			res.rem  = acc - trial;
			res.root = {root[ROOT_W-2:0], 1'b1};
		end else begin
			res.rem  = acc;
			res.root = {root[ROOT_W-2:0], 1'b0};
		end
		return res;
	endfunction

endpackage

// File: rtl/rsd_sqrt_pipe.sv
// Integer square root of (radicand << 16), one result bit per stage.
module rsd_sqrt_pipe import rsd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [SQ_W-1:0]   radicand,
	input  sq_side_t          in_side,
	output logic              out_valid,
	output logic [ROOT_W-1:0] root,
	output sq_side_t          out_side
);

	logic              v_s    [ROOT_W];
	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [RAD_W-1:0]  rad_s  [ROOT_W];
	sq_side_t          side_s [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		// previous stage index, kept in range for the first stage
		localparam int PK = (k == 0) ? 0 : k - 1;

		logic              v_prev;
		logic [REM_W-1:0]  rem_prev;
		logic [ROOT_W-1:0] root_prev;
		logic [RAD_W-1:0]  rad_prev;
		sq_side_t          side_prev;
		sqrt_acc_t         step;

		// stage input: pipe entry or previous stage
		always_comb begin
			if (k == 0) begin
				v_prev    = in_valid;
				rem_prev  = '0;
				root_prev = '0;
				rad_prev  = {radicand, {(RAD_W-SQ_W){1'b0}}};
				side_prev = in_side;
			end else begin
				v_prev    = v_s[PK];
				rem_prev  = rem_s[PK];
				root_prev = root_s[PK];
				rad_prev  = rad_s[PK];
				side_prev = side_s[PK];
			end
			step = sqrt_step(rem_prev, root_prev, rad_prev[RAD_W-1 -: 2]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= step.rem;
				root_s[k] <= step.root;
				rad_s[k]  <= {rad_prev[RAD_W-3:0], 2'b00};
				side_s[k] <= side_prev;
			end
		end
	end

	assign out_valid = v_s[ROOT_W-1];
	assign root      = root_s[ROOT_W-1];
	assign out_side  = side_s[ROOT_W-1];

endmodule

// File: rtl/rsd_div_pipe.sv
// Restoring divider, two lanes sharing one divisor, one quotient bit per stage.
// Divisor is den_prod << 8; an overflowed lane reads as all ones.
module rsd_div_pipe import rsd_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [LANES-1:0][NUM_W-1:0] num,
	input  logic [LANES-1:0]            ovf,
	input  logic [DEN_W-1:0]            den_prod,
	input  dv_side_t                    in_side,
	output logic                        out_valid,
	output logic [LANES-1:0][Q_W-1:0]   quo,
	output dv_side_t                    out_side
);

	logic                        v_s    [Q_W];
	logic [LANES-1:0][NUM_W-1:0] rem_s  [Q_W];
	logic [LANES-1:0][Q_W-1:0]   quo_s  [Q_W];
	logic [LANES-1:0]            ovf_s  [Q_W];
	dv_side_t                    side_s [Q_W];

	for (genvar j = 0; j < Q_W; j++) begin : g_stage
		// previous stage index, kept in range for the first stage
		localparam int PJ = (j == 0) ? 0 : j - 1;

		logic                        v_prev;
		logic [LANES-1:0][NUM_W-1:0] rem_prev;
		logic [LANES-1:0][Q_W-1:0]   quo_prev;
		logic [LANES-1:0]            ovf_prev;
		dv_side_t                    side_prev;
		logic [NUM_W-1:0]            dsh;
		logic [LANES-1:0][NUM_W-1:0] rem_next;
		logic [LANES-1:0][Q_W-1:0]   quo_next;

		// stage input: pipe entry or previous stage
		always_comb begin
			if (j == 0) begin
				v_prev    = in_valid;
				rem_prev  = num;
				quo_prev  = '0;
				ovf_prev  = ovf;
				side_prev = in_side;
			end else begin
				v_prev    = v_s[PJ];
				rem_prev  = rem_s[PJ];
				quo_prev  = quo_s[PJ];
				ovf_prev  = ovf_s[PJ];
				side_prev = side_s[PJ];
			end
		end

		// trial subtract of the divisor aligned to this quotient bit
		always_comb begin
			dsh = NUM_W'(den_prod) << (RADIX_SHIFT + Q_W - 1 - j);
			for (int l = 0; l < LANES; l++) begin
				if (rem_prev[l] >= dsh) begin
					rem_next[l] = rem_prev[l] - dsh;
					quo_next[l] = {quo_prev[l][Q_W-2:0], 1'b1};
				end else begin
					rem_next[l] = rem_prev[l];
					quo_next[l] = {quo_prev[l][Q_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= rem_next;
				quo_s[j]  <= quo_next;
				ovf_s[j]  <= ovf_prev;
				side_s[j] <= side_prev;
			end
		end
	end

	// saturate lanes whose quotient does not fit
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			quo[l] = ovf_s[Q_W-1][l] ? {Q_W{1'b1}} : quo_s[Q_W-1][l];
		end
	end

	assign out_valid = v_s[Q_W-1];
	assign out_side  = side_s[Q_W-1];

endmodule

// File: rtl/rsd_out_buf.sv
// Two-entry result buffer; decouples the pipeline from receiver stalls.
module rsd_out_buf import rsd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_data,
	output logic      full,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	out_item_t  mem [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;
	logic       pop;

	assign pop = result_valid && result_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	assign result       = mem[rd_q];
	assign result_valid = (count_q != 2'd0);
	assign full         = count_q[1];

endmodule

// File: rtl/radial_stick_deadzone_unit.sv
// Scaled radial dead zone for one two-axis stick.
// Sample channel: sample_valid/sample_ready carry one (x_raw, y_raw) pair per
// transaction; result channel: result_valid/result_ready carry (x_scaled,
// y_scaled, in_dead_zone). Every sample gives exactly one result, in order.
// Configuration: cfg_we with cfg_index 0 writes full_scale, 1 writes
// dead_radius (low 15 bits of cfg_wdata); write only while the unit is idle.
// Path: three front stages, 24 square-root stages, three scaling stages, 16
// divider stages, one saturation stage and the two-entry output buffer.
// Throughput: one sample per cycle while the pipeline is not held; every
// stage moves on a shared enable.
// When the receiver stalls, results collect in the output buffer; once it is
// full and the last stage holds a result, the whole pipeline holds and
// sample_ready drops, with nothing lost or repeated.
// Reset clears all valid bits and the buffer and loads full_scale 32767 and
// dead_radius 7849.
`include "assert_macros.svh"

module radial_stick_deadzone_unit import rsd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  in_item_t             sample,
	output logic                 result_valid,
	input  logic                 result_ready,
	output out_item_t            result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	logic [CFG_W-1:0]   full_scale_q;
	logic [CFG_W-1:0]   dead_radius_q;
	logic [2*CFG_W-1:0] fsq_q;
	logic [2*CFG_W-1:0] dsq_q;
	logic [DEN_W-1:0]   den_prod_q;

	logic en;
	logic buf_full;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q  <= FULL_SCALE_RST;
			dead_radius_q <= DEAD_RADIUS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FULL_SCALE:  full_scale_q  <= cfg_wdata;
				CFG_DEAD_RADIUS: dead_radius_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// derived constants, settled long before any sample reaches them
	always_ff @(posedge clk) begin
		fsq_q      <= full_scale_q * full_scale_q;
		dsq_q      <= dead_radius_q * dead_radius_q;
		den_prod_q <= full_scale_q * CFG_W'(full_scale_q - dead_radius_q);
	end

	// stage 1: capture
	logic     v_s1;
	in_item_t smp_s1;

	// stage 2: magnitude and square of each axis
	logic                           v_s2;
	logic [LANES-1:0][SAMPLE_W-1:0] mag_s2;
	logic [LANES-1:0]               neg_s2;
	logic [LANES-1:0][SQ_W-1:0]     sq_s2;

	// stage 3: sum of squares and radius tests
	logic      v_s3;
	logic [SQ_W-1:0] sum_s3;
	sq_side_t  side_s3;

	logic [LANES-1:0][SAMPLE_W-1:0] raw_c;
	logic [LANES-1:0][SAMPLE_W-1:0] mag_c;
	logic [SQ_W-1:0]                sum_c;

	always_comb begin
		raw_c[0] = smp_s1.x_raw;
		raw_c[1] = smp_s1.y_raw;
		for (int l = 0; l < LANES; l++) begin
			mag_c[l] = raw_c[l][SAMPLE_W-1] ? (~raw_c[l] + 1'b1) : raw_c[l];
		end
		sum_c = SQ_W'({1'b0, sq_s2[0]} + {1'b0, sq_s2[1]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			smp_s1 <= sample;
			for (int l = 0; l < LANES; l++) begin
				mag_s2[l] <= mag_c[l];
				neg_s2[l] <= raw_c[l][SAMPLE_W-1];
				sq_s2[l]  <= mag_c[l] * mag_c[l];
			end
			sum_s3        <= sum_c;
			side_s3.mag   <= mag_s2;
			side_s3.neg   <= neg_s2;
			side_s3.dead  <= sum_c < SQ_W'(dsq_q);
			side_s3.kill  <= (sum_c < SQ_W'(dsq_q)) || (dead_radius_q >= full_scale_q);
			side_s3.clamp <= sum_c > SQ_W'(fsq_q);
		end
	end

	// radius
	logic              v_sq;
	logic [ROOT_W-1:0] root_sq;
	sq_side_t          side_sq;

	rsd_sqrt_pipe u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.radicand (sum_s3),
		.in_side  (side_s3),
		.out_valid(v_sq),
		.root     (root_sq),
		.out_side (side_sq)
	);

	// stage 4: excess of the clamped radius over the dead radius
	logic             v_s4;
	logic [EXC_W-1:0] exc_s4;
	sq_side_t         side_s4;
	logic [ROOT_W-1:0] rad_c;

	always_comb begin
		rad_c = side_sq.clamp ? ROOT_W'({full_scale_q, {RADIX_SHIFT{1'b0}}}) : root_sq;
	end

	// stage 5: axis magnitude times excess
	logic                         v_s5;
	logic [LANES-1:0][PROD_W-1:0] prod_s5;
	dv_side_t                     side_s5;

	// stage 6: rounded dividend and overflow test
	logic                        v_s6;
	logic [LANES-1:0][NUM_W-1:0] num_s6;
	logic [LANES-1:0]            ovf_s6;
	dv_side_t                    side_s6;
	logic [LANES-1:0][NUM_W-1:0] num_c;
	logic [NUM_W-1:0]            den_half_c;
	logic [NUM_W-1:0]            den_top_c;

	always_comb begin
		den_half_c = NUM_W'(den_prod_q) << (RADIX_SHIFT - 1);
		den_top_c  = NUM_W'(den_prod_q) << (RADIX_SHIFT + Q_W);
		for (int l = 0; l < LANES; l++) begin
			num_c[l] = (NUM_W'(prod_s5[l]) << FRAC_SHIFT) + den_half_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_sq;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			exc_s4  <= EXC_W'(rad_c - ROOT_W'({dead_radius_q, {RADIX_SHIFT{1'b0}}}));
			side_s4 <= side_sq;
			for (int l = 0; l < LANES; l++) begin
				prod_s5[l] <= side_s4.mag[l] * exc_s4;
				num_s6[l]  <= num_c[l];
				ovf_s6[l]  <= num_c[l] >= den_top_c;
			end
			side_s5.neg  <= side_s4.neg;
			side_s5.dead <= side_s4.dead;
			side_s5.kill <= side_s4.kill;
			side_s6      <= side_s5;
		end
	end

	// division by full_scale * (full_scale - dead_radius)
	logic                      v_dv;
	logic [LANES-1:0][Q_W-1:0] quo_dv;
	dv_side_t                  side_dv;

	rsd_div_pipe u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s6),
		.num      (num_s6),
		.ovf      (ovf_s6),
		.den_prod (den_prod_q),
		.in_side  (side_s6),
		.out_valid(v_dv),
		.quo      (quo_dv),
		.out_side (side_dv)
	);

	// stage 7: sign, saturation and zeroing in the dead zone or when dead_radius >= full_scale
	logic                           v_s7;
	out_item_t                      res_s7;
	logic [LANES-1:0][SAMPLE_W-1:0] val_c;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (side_dv.kill) begin
				val_c[l] = '0;
			end else if (side_dv.neg[l]) begin
				val_c[l] = quo_dv[l][Q_W-1] ? OUT_MIN : SAMPLE_W'(~quo_dv[l] + 1'b1);
			end else begin
				val_c[l] = quo_dv[l][Q_W-1] ? OUT_MAX : SAMPLE_W'(quo_dv[l]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s7.x_scaled     <= val_c[0];
			res_s7.y_scaled     <= val_c[1];
			res_s7.in_dead_zone <= side_dv.dead;
		end
	end

	// pipeline holds only when the buffer is full and a result waits at the end
	assign en           = !buf_full || !v_s7;
	assign sample_ready = en;

	rsd_out_buf u_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (v_s7 && en),
		.push_data   (res_s7),
		.full        (buf_full),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	// checks
	`ASSERT_IMPLIES(a_dead_zero, clk, arst_n, result_valid && result.in_dead_zone,
		result.x_scaled == '0 && result.y_scaled == '0, "dead-zone result not zero")
	`ASSERT_IMPLIES(a_no_push_full, clk, arst_n, v_s7 && en, !buf_full,
		"result pushed into full buffer")
	`ASSERT_NEXT(a_hold_stage, clk, arst_n, !en && v_s7, v_s7,
		"stalled result lost from last stage")

endmodule

// File: verif/tb_radial_stick_deadzone_unit.sv
module tb_radial_stick_deadzone_unit;
	import rsd_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 80;

	// predicts each result and holds the ones still owed by the unit
	class deadzone_scoreboard;
		out_item_t owed[$];
		int        errors;
		logic [CFG_W-1:0] full_scale;
		logic [CFG_W-1:0] dead_radius;

		function new();
			full_scale  = FULL_SCALE_RST;
			dead_radius = DEAD_RADIUS_RST;
			errors      = 0;
		endfunction

		// bitwise integer square root
		function automatic longint unsigned int_sqrt(longint unsigned v);
			longint unsigned root;
			longint unsigned bitpos;
			root   = 0;
			bitpos = 64'd1 << 62;
			while (bitpos > v)
				bitpos >>= 2;
			while (bitpos != 0) begin
				if (v >= root + bitpos) begin
					v    = v - (root + bitpos);
					root = (root >> 1) + bitpos;
				end else begin
					root >>= 1;
				end
				bitpos >>= 2;
			end
			return root;
		endfunction

		function automatic logic signed [15:0] scale_lane(longint a,
			longint unsigned excess, longint unsigned den);
			longint unsigned mag;
			longint          q;
			mag = (a < 0) ? -a : a;
			q   = longint'((mag * excess * 64'd32768 + den / 2) / den);
			if (a < 0)
				q = -q;
			if (q > 32767)
				q = 32767;
			if (q < -32768)
				q = -32768;
			return q[15:0];
		endfunction

		function void note_sample(in_item_t s);
			out_item_t       e;
			longint          x, y;
			longint unsigned sq, d, f, rad, den;
			x  = longint'(s.x_raw);
			y  = longint'(s.y_raw);
			sq = longint'(x * x) + longint'(y * y);
			d  = 64'(dead_radius);
			f  = 64'(full_scale);
			e  = '0;
			e.in_dead_zone = (sq < d * d);
			if (!e.in_dead_zone && d < f) begin
				den = f * (f - d) * 256;
				rad = (sq > f * f) ? f * 256 : int_sqrt(sq << 16);
				e.x_scaled = scale_lane(x, rad - d * 256, den);
				e.y_scaled = scale_lane(y, rad - d * 256, den);
			end
			owed.push_back(e);
		endfunction

		task check_result(out_item_t r);
			out_item_t e;
			if (owed.size() == 0) begin
				report("result with no sample pending");
				return;
			end
			e = owed.pop_front();
			if (r.x_scaled !== e.x_scaled)
				report($sformatf("x_scaled %0d, predicted %0d", r.x_scaled, e.x_scaled));
			if (r.y_scaled !== e.y_scaled)
				report($sformatf("y_scaled %0d, predicted %0d", r.y_scaled, e.y_scaled));
			if (r.in_dead_zone !== e.in_dead_zone)
				report($sformatf("in_dead_zone %0b, predicted %0b",
					r.in_dead_zone, e.in_dead_zone));
		endtask

		task report(string msg);
			errors++;
			$display("mismatch: %s (f=%0d d=%0d)", msg, full_scale, dead_radius);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        sample_valid = 1'b0;
	logic        sample_ready;
	in_item_t    sample = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	out_item_t   result;
	logic        cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	deadzone_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	radial_stick_deadzone_unit dut (.*);

	// sampling at the rising edge: transactions and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && sample_ready)
				sb.note_sample(sample);
			if (result_valid && result_ready)
				sb.check_result(result);
			if ((sample_valid && sample_ready) || (result_valid && result_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired");
				$display("FAIL");
				$finish;
			end
		end
	end

	// receiver stall, changed at the falling edge
	always @(negedge clk)
		result_ready <= ($urandom_range(99) >= recv_stall_pct);

	task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample <= '{x_raw: x, y_raw: y};
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
	endtask

	task automatic go_idle();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (sb.owed.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_FULL_SCALE)
			sb.full_scale = val;
		else
			sb.dead_radius = val;
	endtask

	// well-formed samples mostly near the interesting radii, rest full range
	task automatic random_sample();
		int kind;
		int r;
		kind = $urandom_range(9);
		r = int'((sb.full_scale > sb.dead_radius) ? sb.full_scale : sb.dead_radius);
		if (kind < 6 && r > 0)
			send_sample($signed(16'($urandom_range(2 * r) - r)),
				$signed(16'($urandom_range(2 * r) - r)));
		else
			send_sample(16'($urandom), 16'($urandom));
	endtask

	initial begin
		int fs[6] = '{32767, 1, 1000, 20000, 500, 32767};
		int dr[6] = '{0, 0, 999, 5000, 600, 32767};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset settings, extremes of the axes
		send_sample(16'sh0000, 16'sh0000);
		send_sample(16'sh7FFF, 16'sh7FFF);
		send_sample(16'sh8000, 16'sh8000);
		send_sample(16'sh8000, 16'sh7FFF);
		send_sample(16'sh7FFF, 16'sh0000);
		send_sample(16'sh0000, 16'sh8000);
		send_sample(16'd7848, 16'd0);
		send_sample(16'd7849, 16'd0);
		send_sample(-16'sd7849, 16'd0);
		send_sample(16'd5550, 16'd5550);
		send_sample(16'd20000, -16'sd20000);
		send_sample(16'hFFFF, 16'h5555);
		send_sample(16'hAAAA, 16'h5555);
		go_idle();
		// dead radius not below full scale, and small full scale saturating
		write_reg(CFG_DEAD_RADIUS, 15'd100);
		write_reg(CFG_FULL_SCALE, 15'd100);
		send_sample(16'd300, 16'd300);
		send_sample(16'd50, 16'd0);
		go_idle();
		write_reg(CFG_FULL_SCALE, 15'd1);
		write_reg(CFG_DEAD_RADIUS, 15'd0);
		send_sample(16'd1, 16'd0);
		send_sample(16'd0, 16'd0);
		send_sample(-16'sd32768, 16'd1);
		go_idle();

		// random phases over several settings and idling mixes
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(CFG_FULL_SCALE, CFG_W'(fs[ph]));
			write_reg(CFG_DEAD_RADIUS, CFG_W'(dr[ph]));
			for (int i = 0; i < 108; i++) begin
				case ((ph + i / 27) % 4)
					0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
					1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
					2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
					default: begin send_idle_pct = 33; recv_stall_pct = 33; end
				endcase
				random_sample();
			end
			go_idle();
		end

		recv_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+rtl
rtl/rsd_pkg.sv
rtl/rsd_sqrt_pipe.sv
rtl/rsd_div_pipe.sv
rtl/rsd_out_buf.sv
rtl/radial_stick_deadzone_unit.sv
verif/tb_radial_stick_deadzone_unit.sv
